// File: hdl/register_vm_execute_unit_macros.svh
// Assertion macros shared by the checker of the register machine execute unit.
`ifndef REGISTER_VM_EXECUTE_UNIT_MACROS_SVH
`define REGISTER_VM_EXECUTE_UNIT_MACROS_SVH

// Property checked on every rising edge of aclk outside of reset.
`define RVX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Property checked on every rising edge of aclk, reset cycles included.
`define RVX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

// File: hdl/rvx_pkg.sv
// Types and constants shared by the register machine execute unit.
`timescale 1ns / 1ps

package rvx_pkg;

    // Register file size and operand layout.
    localparam int NUM_REGS = 16;
    localparam int REG_AW   = $clog2(NUM_REGS);
    localparam int OPER_W   = 32;
    localparam int FUNC_W   = 5;

    // Stream widths and bit positions.
    localparam int IN_TDATA_W    = 3 * OPER_W;
    localparam int IN_TUSER_W    = FUNC_W + 1;
    localparam int TUSER_HAS_B   = FUNC_W;
    localparam int OUT_TDATA_W   = 104;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DIM_W  = 7;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_DISPLAY_ENABLED = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_DISPLAY_HEIGHT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_DISPLAY_WIDTH   = 2'd2;
    localparam logic [CFG_DIM_W-1:0]  CFG_DIM_RESET           = 7'd64;

    // Request queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH  = 5'd0,
        OP_JREQ  = 5'd1,
        OP_PULL  = 5'd2,
        OP_PRNT  = 5'd3,
        OP_PURGE = 5'd4,
        OP_HALT  = 5'd5,
        OP_ADD   = 5'd6,
        OP_SUB   = 5'd7,
        OP_ADD_R = 5'd8,
        OP_SUB_R = 5'd9,
        OP_INC   = 5'd10,
        OP_DEC   = 5'd11,
        OP_CMRR  = 5'd12,
        OP_COMP  = 5'd13,
        OP_JPEQ  = 5'd14,
        OP_DPFB  = 5'd15,
        OP_NOP   = 5'd16
    } op_t;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_HALTED     = 3'd1,
        STS_OCCUPIED   = 3'd2,
        STS_DEC_EMPTY  = 3'd3,
        STS_NO_DISPLAY = 3'd4,
        STS_PIX_RANGE  = 3'd5
    } status_t;

    // One classified instruction as it travels through the queue.
    typedef struct packed {
        op_t               op;
        logic [OPER_W-1:0] a;
        logic [OPER_W-1:0] b;
        logic [OPER_W-1:0] c;
        logic              has_b;
        logic [REG_AW-1:0] ra;
        logic [REG_AW-1:0] rb;
        logic [REG_AW-1:0] rc;
    } instr_t;

    // Result word, status in the lowest bits.
    typedef struct packed {
        logic              pixel_value;
        logic [OPER_W-1:0] exit_code;
        logic [OPER_W-1:0] print_value;
        logic              print_is_null;
        logic              print_is_char;
        logic              print_valid;
        logic [OPER_W-1:0] jump_target;
        logic              jump_taken;
        status_t           status;
    } result_t;

    // Display configuration.
    typedef struct packed {
        logic                 disp_en;
        logic [CFG_DIM_W-1:0] disp_h;
        logic [CFG_DIM_W-1:0] disp_w;
    } cfg_t;

endpackage

// File: hdl/rvx_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module rvx_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/rvx_front.sv
// Front end: accepts instruction requests, classifies them and queues them.
`timescale 1ns / 1ps

module rvx_front #(
    parameter int FB_ROWS = 64,
    parameter int FB_COLS = 64,
    localparam int FbDepth = FB_ROWS * FB_COLS,
    localparam int FbAw = (FbDepth > 1) ? $clog2(FbDepth) : 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rvx_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [rvx_pkg::IN_TUSER_W-1:0]     s_tuser,
    input  logic                               clearing,
    output logic                               q_valid,
    input  logic                               q_ready,
    output rvx_pkg::instr_t                    q_item,
    output logic [FbAw-1:0]                    q_fb_addr
);

    localparam int RowW = (FB_ROWS > 1) ? $clog2(FB_ROWS) : 1;
    localparam int ColW = (FB_COLS > 1) ? $clog2(FB_COLS) : 1;
    localparam int OpW  = rvx_pkg::OPER_W;

    rvx_pkg::instr_t                 entry_reg [rvx_pkg::Q_DEPTH];
    logic [FbAw-1:0]                 fb_addr_reg [rvx_pkg::Q_DEPTH];
    logic [rvx_pkg::Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rvx_pkg::Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rvx_pkg::Q_CNT_W-1:0]     count_reg, count_next;
    rvx_pkg::instr_t                 dec_item;
    logic [FbAw-1:0]                 dec_fb_addr;
    logic [rvx_pkg::FUNC_W-1:0]      func;
    logic                            push;
    logic                            pop;

    assign func = s_tuser[rvx_pkg::FUNC_W-1:0];

    // Decode: unused function codes become a no-op, register indexes are the
    // low operand bits and the pixel address is row times columns plus column.
    always_comb begin
        dec_item.op    = (func <= rvx_pkg::OP_NOP) ? rvx_pkg::op_t'(func) : rvx_pkg::OP_NOP;
        dec_item.a     = s_tdata[OpW-1:0];
        dec_item.b     = s_tdata[2*OpW-1:OpW];
        dec_item.c     = s_tdata[3*OpW-1:2*OpW];
        dec_item.has_b = s_tuser[rvx_pkg::TUSER_HAS_B];
        dec_item.ra    = s_tdata[rvx_pkg::REG_AW-1:0];
        dec_item.rb    = s_tdata[OpW+rvx_pkg::REG_AW-1:OpW];
        dec_item.rc    = s_tdata[2*OpW+rvx_pkg::REG_AW-1:2*OpW];
        dec_fb_addr    = FbAw'(32'(s_tdata[RowW-1:0]) * 32'(FB_COLS)
                               + 32'(s_tdata[OpW+ColW-1:OpW]));
    end

    // Queue handshakes; no request is taken while the framebuffer is cleared.
    assign s_tready = (count_reg != rvx_pkg::Q_CNT_W'(rvx_pkg::Q_DEPTH)) && !clearing;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_item    = entry_reg[rd_ptr_reg];
    assign q_fb_addr = fb_addr_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg]   <= dec_item;
            fb_addr_reg[wr_ptr_reg] <= dec_fb_addr;
        end
    end

endmodule

// File: hdl/rvx_back.sv
// Back end: reads operands, executes one instruction and holds the result.
`timescale 1ns / 1ps

module rvx_back #(
    parameter int FB_ROWS = 64,
    parameter int FB_COLS = 64,
    localparam int FbDepth = FB_ROWS * FB_COLS,
    localparam int FbAw = (FbDepth > 1) ? $clog2(FbDepth) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rvx_pkg::cfg_t     cfg,
    input  logic              q_valid,
    output logic              q_ready,
    input  rvx_pkg::instr_t   q_item,
    input  logic [FbAw-1:0]   q_fb_addr,
    output logic              clearing,
    output logic              m_tvalid,
    input  logic              m_tready,
    output rvx_pkg::result_t  m_result
);

    localparam int OpW = rvx_pkg::OPER_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                          state_reg, state_next;
    logic                            m_valid_reg, m_valid_next;
    rvx_pkg::result_t                result_reg, result_next;
    rvx_pkg::instr_t                 instr_reg, instr_next;
    logic [FbAw-1:0]                 fb_addr_reg, fb_addr_next;
    logic [rvx_pkg::NUM_REGS-1:0]    empty_reg, empty_next;
    logic                            eq_reg, eq_next;
    logic                            stopped_reg, stopped_next;
    logic [FbAw-1:0]                 clr_cnt_reg, clr_cnt_next;

    logic                            rd_en;
    logic                            exec_fire;
    logic [OpW-1:0]                  rf_a_rdata, rf_b_rdata;
    logic [OpW-1:0]                  val_a, val_b, step;
    logic                            rf_we;
    logic [rvx_pkg::REG_AW-1:0]      rf_waddr;
    logic [OpW-1:0]                  rf_wdata;
    logic                            fb_we;
    logic [FbAw-1:0]                 fb_waddr;
    logic                            fb_wdata;
    logic                            fb_rdata;
    logic                            pix_in_range;
    rvx_pkg::result_t                exec_res;

    // Operand reads are issued while the request leaves the queue.
    assign q_ready   = (state_reg == S_IDLE);
    assign rd_en     = q_valid && q_ready;
    assign clearing  = (state_reg == S_CLEAR);
    assign exec_fire = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);

    rvx_ram #(.WIDTH(OpW), .DEPTH(rvx_pkg::NUM_REGS)) u_rf_a (
        .aclk    (aclk),
        .wr_en   (rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata),
        .rd_en   (rd_en),
        .rd_addr (q_item.ra),
        .rd_data (rf_a_rdata)
    );

    rvx_ram #(.WIDTH(OpW), .DEPTH(rvx_pkg::NUM_REGS)) u_rf_b (
        .aclk    (aclk),
        .wr_en   (rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata),
        .rd_en   (rd_en),
        .rd_addr (q_item.rb),
        .rd_data (rf_b_rdata)
    );

    rvx_ram #(.WIDTH(1), .DEPTH(FbDepth)) u_fb (
        .aclk    (aclk),
        .wr_en   (fb_we),
        .wr_addr (fb_waddr),
        .wr_data (fb_wdata),
        .rd_en   (rd_en),
        .rd_addr (q_fb_addr),
        .rd_data (fb_rdata)
    );

    // An empty register always holds zero, so its stale RAM word is masked.
    assign val_a = empty_reg[instr_reg.ra] ? '0 : rf_a_rdata;
    assign val_b = empty_reg[instr_reg.rb] ? '0 : rf_b_rdata;
    assign step  = instr_reg.has_b ? instr_reg.b : OpW'(1);

    // Pixel row and column must lie inside both the display and the buffer.
    assign pix_in_range = (instr_reg.a < OpW'(cfg.disp_h)) && (instr_reg.a < OpW'(FB_ROWS))
                       && (instr_reg.b < OpW'(cfg.disp_w)) && (instr_reg.b < OpW'(FB_COLS));

    // Sequencer, execution and writeback.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        result_next  = result_reg;
        instr_next   = instr_reg;
        fb_addr_next = fb_addr_reg;
        empty_next   = empty_reg;
        eq_next      = eq_reg;
        stopped_next = stopped_reg;
        clr_cnt_next = clr_cnt_reg;
        rf_we        = 1'b0;
        rf_waddr     = instr_reg.rc;
        rf_wdata     = '0;
        fb_we        = 1'b0;
        fb_waddr     = fb_addr_reg;
        fb_wdata     = 1'b0;
        exec_res     = '0;

        unique case (state_reg)
            S_CLEAR: begin
                fb_we    = 1'b1;
                fb_waddr = clr_cnt_reg;
                if (clr_cnt_reg == FbAw'(FbDepth - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + FbAw'(1);
                end
            end
            S_IDLE: begin
                if (q_valid) begin
                    instr_next   = q_item;
                    fb_addr_next = q_fb_addr;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_fire) begin
                    if (stopped_reg) begin
                        exec_res.status = rvx_pkg::STS_HALTED;
                    end else begin
                        unique case (instr_reg.op)
                            rvx_pkg::OP_PUSH: begin
                                if (empty_reg[instr_reg.rb]) begin
                                    rf_we                   = 1'b1;
                                    rf_waddr                = instr_reg.rb;
                                    rf_wdata                = instr_reg.a;
                                    empty_next[instr_reg.rb] = 1'b0;
                                end else begin
                                    exec_res.status = rvx_pkg::STS_OCCUPIED;
                                    stopped_next    = 1'b1;
                                end
                            end
                            rvx_pkg::OP_JREQ: begin
                                if (val_a == instr_reg.b) begin
                                    exec_res.jump_taken  = 1'b1;
                                    exec_res.jump_target = instr_reg.c;
                                end
                            end
                            rvx_pkg::OP_PULL: begin
                                if (!cfg.disp_en) begin
                                    exec_res.print_valid   = 1'b1;
                                    exec_res.print_is_null = empty_reg[instr_reg.ra];
                                    exec_res.print_value   = val_a;
                                end
                            end
                            rvx_pkg::OP_PRNT: begin
                                if (!cfg.disp_en) begin
                                    exec_res.print_valid   = 1'b1;
                                    exec_res.print_is_char = 1'b1;
                                    exec_res.print_value   = OpW'(instr_reg.a[7:0]);
                                end
                            end
                            rvx_pkg::OP_PURGE: begin
                                rf_we                    = 1'b1;
                                rf_waddr                 = instr_reg.ra;
                                empty_next[instr_reg.ra] = 1'b1;
                            end
                            rvx_pkg::OP_HALT: begin
                                exec_res.status    = rvx_pkg::STS_HALTED;
                                exec_res.exit_code = instr_reg.a;
                                stopped_next       = 1'b1;
                            end
                            rvx_pkg::OP_ADD, rvx_pkg::OP_SUB: begin
                                rf_we    = 1'b1;
                                rf_wdata = (instr_reg.op == rvx_pkg::OP_ADD)
                                         ? instr_reg.a + instr_reg.b
                                         : instr_reg.a - instr_reg.b;
                                empty_next[instr_reg.rc] = 1'b0;
                            end
                            rvx_pkg::OP_ADD_R, rvx_pkg::OP_SUB_R: begin
                                rf_we    = 1'b1;
                                rf_wdata = (instr_reg.op == rvx_pkg::OP_ADD_R)
                                         ? val_a + val_b : val_a - val_b;
                                empty_next[instr_reg.rc] = 1'b0;
                            end
                            rvx_pkg::OP_INC: begin
                                rf_we                    = 1'b1;
                                rf_waddr                 = instr_reg.ra;
                                rf_wdata                 = val_a + step;
                                empty_next[instr_reg.ra] = 1'b0;
                            end
                            rvx_pkg::OP_DEC: begin
                                if (empty_reg[instr_reg.ra]) begin
                                    exec_res.status = rvx_pkg::STS_DEC_EMPTY;
                                    stopped_next    = 1'b1;
                                end else begin
                                    rf_we    = 1'b1;
                                    rf_waddr = instr_reg.ra;
                                    rf_wdata = val_a - step;
                                end
                            end
                            rvx_pkg::OP_CMRR: begin
                                if (!empty_reg[instr_reg.ra]) begin
                                    rf_we                    = 1'b1;
                                    rf_waddr                 = instr_reg.rb;
                                    rf_wdata                 = val_a;
                                    empty_next[instr_reg.rb] = 1'b0;
                                end
                            end
                            rvx_pkg::OP_COMP: begin
                                eq_next = (instr_reg.a == instr_reg.b);
                            end
                            rvx_pkg::OP_JPEQ: begin
                                // The flag is tested first and cleared afterwards.
                                if (eq_reg) begin
                                    exec_res.jump_taken  = 1'b1;
                                    exec_res.jump_target = instr_reg.a;
                                end
                                eq_next = 1'b0;
                            end
                            rvx_pkg::OP_DPFB: begin
                                if (!cfg.disp_en) begin
                                    exec_res.status = rvx_pkg::STS_NO_DISPLAY;
                                    stopped_next    = 1'b1;
                                end else if (!pix_in_range) begin
                                    exec_res.status = rvx_pkg::STS_PIX_RANGE;
                                end else begin
                                    fb_we                = 1'b1;
                                    fb_wdata             = ~fb_rdata;
                                    exec_res.pixel_value = ~fb_rdata;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    m_valid_next = 1'b1;
                    result_next  = exec_res;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
            empty_reg   <= '1;
            eq_reg      <= 1'b0;
            stopped_reg <= 1'b0;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            empty_reg   <= empty_next;
            eq_reg      <= eq_next;
            stopped_reg <= stopped_next;
            clr_cnt_reg <= clr_cnt_next;
        end
        result_reg  <= result_next;
        instr_reg   <= instr_next;
        fb_addr_reg <= fb_addr_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_result = result_reg;

endmodule

// File: hdl/register_vm_execute_unit.sv
// Top level of the register machine execute unit.
`timescale 1ns / 1ps

// Executes one decoded instruction per request and answers each with one
// result. In the back end each instruction first gets a registered read of
// the register file and the framebuffer, then executes and writes back once
// the output register is free; no new request is taken before that.
// A two-entry request queue in front and the output register let input and
// output stall independently. After reset the framebuffer is cleared one
// pixel per cycle, all FB_ROWS * FB_COLS pixels (4096 at the default size),
// during which s_tready stays low; configuration writes are taken at any time.
// After a halt or a fatal error every request answers halted until reset.
module register_vm_execute_unit #(
    parameter int FB_ROWS = 64,
    parameter int FB_COLS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rvx_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [rvx_pkg::CFG_DIM_W-1:0]       cfg_data,
    // Instruction requests.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // operand_a [31:0], operand_b [63:32], operand_c [95:64]
    input  logic [rvx_pkg::IN_TDATA_W-1:0]      s_tdata,
    // func [4:0], has_b [5]
    input  logic [rvx_pkg::IN_TUSER_W-1:0]      s_tuser,
    // Results.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status [2:0], jump_taken [3], jump_target [35:4], print_valid [36],
    // print_is_char [37], print_is_null [38], print_value [70:39],
    // exit_code [102:71], pixel_value [103]
    output logic [rvx_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int FbDepth = FB_ROWS * FB_COLS;
    localparam int FbAw    = (FbDepth > 1) ? $clog2(FbDepth) : 1;

    rvx_pkg::cfg_t      cfg_reg, cfg_next;
    rvx_pkg::instr_t    q_item;
    rvx_pkg::result_t   m_result;
    logic [FbAw-1:0]    q_fb_addr;
    logic               q_valid;
    logic               q_ready;
    logic               clearing;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                rvx_pkg::CFG_IDX_DISPLAY_ENABLED: cfg_next.disp_en = cfg_data[0];
                rvx_pkg::CFG_IDX_DISPLAY_HEIGHT:  cfg_next.disp_h  = cfg_data;
                rvx_pkg::CFG_IDX_DISPLAY_WIDTH:   cfg_next.disp_w  = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.disp_en <= 1'b0;
            cfg_reg.disp_h  <= rvx_pkg::CFG_DIM_RESET;
            cfg_reg.disp_w  <= rvx_pkg::CFG_DIM_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rvx_front #(.FB_ROWS(FB_ROWS), .FB_COLS(FB_COLS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .q_fb_addr (q_fb_addr)
    );

    rvx_back #(.FB_ROWS(FB_ROWS), .FB_COLS(FB_COLS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .q_fb_addr (q_fb_addr),
        .clearing  (clearing),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (m_result)
    );

    assign m_tdata = m_result;

endmodule

// File: hdl/rvx_checker.sv
// Port-level checker for the register machine execute unit, bound to the top.
`timescale 1ns / 1ps
`include "register_vm_execute_unit_macros.svh"

module rvx_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rvx_pkg::OUT_TDATA_W-1:0] m_tdata
);

    rvx_pkg::result_t res;
    rvx_pkg::result_t halted_res;
    logic             stop_status;
    logic             stopped_seen_reg, stopped_seen_next;

    assign res = m_tdata;

    // The only result allowed once the block has stopped.
    always_comb begin
        halted_res        = '0;
        halted_res.status = rvx_pkg::STS_HALTED;
    end

    // Track whether a delivered result stopped the block.
    assign stop_status = (res.status == rvx_pkg::STS_HALTED)
                      || (res.status == rvx_pkg::STS_OCCUPIED)
                      || (res.status == rvx_pkg::STS_DEC_EMPTY)
                      || (res.status == rvx_pkg::STS_NO_DISPLAY);
    assign stopped_seen_next = stopped_seen_reg || (m_tvalid && m_tready && stop_status);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stopped_seen_reg <= 1'b0;
        end else begin
            stopped_seen_reg <= stopped_seen_next;
        end
    end

    `RVX_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid after reset")
    `RVX_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")
    `RVX_ASSERT(a_stopped_only_halted, (m_tvalid && stopped_seen_reg) |-> (res == halted_res), "stopped block gave a result other than halted")
    `RVX_ASSERT(a_jump_target_zero, m_tvalid |-> (res.jump_taken || (res.jump_target == '0)), "jump target without jump")
    `RVX_ASSERT(a_char_print, (m_tvalid && res.print_is_char) |-> (res.print_valid && (res.print_value[31:8] == '0)), "bad character print")

endmodule

bind register_vm_execute_unit rvx_checker u_rvx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/register_vm_execute_unit_test.sv
// Self-checking testbench for the register machine execute unit.
`timescale 1ns / 1ps

// Shadow copy of the machine: predicts one outcome per accepted request.
class vm_shadow_machine;
    localparam int PIX_ROWS = 64;
    localparam int PIX_COLS = 64;

    logic [31:0]        reg_value [rvx_pkg::NUM_REGS];
    bit                 reg_empty [rvx_pkg::NUM_REGS];
    bit                 eq_flag;
    bit                 pixels [PIX_ROWS*PIX_COLS];
    bit                 stopped;
    bit                 disp_en;
    logic [6:0]         disp_h;
    logic [6:0]         disp_w;
    rvx_pkg::result_t   outcomes_due [$];
    int                 accepted;
    int                 compared;
    int                 errors;

    function new();
        for (int i = 0; i < rvx_pkg::NUM_REGS; i++) begin
            reg_value[i] = '0;
            reg_empty[i] = 1'b1;
        end
        foreach (pixels[k]) pixels[k] = 1'b0;
        eq_flag  = 1'b0;
        stopped  = 1'b0;
        disp_en  = 1'b0;
        disp_h   = 7'd64;
        disp_w   = 7'd64;
        accepted = 0;
        compared = 0;
        errors   = 0;
    endfunction

    function void set_config(logic [rvx_pkg::CFG_ADDR_W-1:0] idx,
                             logic [rvx_pkg::CFG_DIM_W-1:0] data);
        case (idx)
            rvx_pkg::CFG_IDX_DISPLAY_ENABLED: disp_en = data[0];
            rvx_pkg::CFG_IDX_DISPLAY_HEIGHT:  disp_h = data;
            rvx_pkg::CFG_IDX_DISPLAY_WIDTH:   disp_w = data;
            default: ;
        endcase
    endfunction

    function int rows_in_use();
        return (disp_h < PIX_ROWS) ? int'(disp_h) : PIX_ROWS;
    endfunction

    function int cols_in_use();
        return (disp_w < PIX_COLS) ? int'(disp_w) : PIX_COLS;
    endfunction

    // Finds a register with the wanted empty mark, starting at a random index.
    function bit pick_reg(bit want_empty, output logic [3:0] idx);
        int start;
        int j;
        start = $urandom_range(0, rvx_pkg::NUM_REGS - 1);
        for (int i = 0; i < rvx_pkg::NUM_REGS; i++) begin
            j = (start + i) % rvx_pkg::NUM_REGS;
            if (reg_empty[j] == want_empty) begin
                idx = j[3:0];
                return 1'b1;
            end
        end
        idx = '0;
        return 1'b0;
    endfunction

    // Executes one accepted instruction on the shadow state.
    function void accept_instr(logic [4:0] fn, logic [31:0] a, logic [31:0] b,
                               logic [31:0] c, logic has_b);
        rvx_pkg::result_t               r;
        logic [rvx_pkg::REG_AW-1:0]     ra;
        logic [rvx_pkg::REG_AW-1:0]     rb;
        logic [rvx_pkg::REG_AW-1:0]     rc;
        logic [31:0]                    step;
        logic [31:0]                    x;
        logic [31:0]                    y;
        int                             k;
        r  = '0;
        ra = a[rvx_pkg::REG_AW-1:0];
        rb = b[rvx_pkg::REG_AW-1:0];
        rc = c[rvx_pkg::REG_AW-1:0];
        step = has_b ? b : 32'd1;
        accepted++;
        if (stopped) begin
            r.status = rvx_pkg::STS_HALTED;
        end else begin
            case (fn)
                rvx_pkg::OP_PUSH: begin
                    if (reg_empty[rb]) begin
                        reg_value[rb] = a;
                        reg_empty[rb] = 1'b0;
                    end else begin
                        r.status = rvx_pkg::STS_OCCUPIED;
                        stopped  = 1'b1;
                    end
                end
                rvx_pkg::OP_JREQ: begin
                    if (reg_value[ra] == b) begin
                        r.jump_taken  = 1'b1;
                        r.jump_target = c;
                    end
                end
                rvx_pkg::OP_PULL: begin
                    if (!disp_en) begin
                        r.print_valid = 1'b1;
                        if (reg_empty[ra])
                            r.print_is_null = 1'b1;
                        else
                            r.print_value = reg_value[ra];
                    end
                end
                rvx_pkg::OP_PRNT: begin
                    if (!disp_en) begin
                        r.print_valid   = 1'b1;
                        r.print_is_char = 1'b1;
                        r.print_value   = {24'd0, a[7:0]};
                    end
                end
                rvx_pkg::OP_PURGE: begin
                    reg_value[ra] = '0;
                    reg_empty[ra] = 1'b1;
                end
                rvx_pkg::OP_HALT: begin
                    r.status    = rvx_pkg::STS_HALTED;
                    r.exit_code = a;
                    stopped     = 1'b1;
                end
                rvx_pkg::OP_ADD, rvx_pkg::OP_SUB: begin
                    reg_value[rc] = (fn == rvx_pkg::OP_ADD) ? a + b : a - b;
                    reg_empty[rc] = 1'b0;
                end
                rvx_pkg::OP_ADD_R, rvx_pkg::OP_SUB_R: begin
                    // Empty sources still hold zero and are used as such.
                    x = reg_value[ra];
                    y = reg_value[rb];
                    reg_value[rc] = (fn == rvx_pkg::OP_ADD_R) ? x + y : x - y;
                    reg_empty[rc] = 1'b0;
                end
                rvx_pkg::OP_INC: begin
                    reg_value[ra] = reg_value[ra] + step;
                    reg_empty[ra] = 1'b0;
                end
                rvx_pkg::OP_DEC: begin
                    if (reg_empty[ra]) begin
                        r.status = rvx_pkg::STS_DEC_EMPTY;
                        stopped  = 1'b1;
                    end else begin
                        reg_value[ra] = reg_value[ra] - step;
                    end
                end
                rvx_pkg::OP_CMRR: begin
                    if (!reg_empty[ra]) begin
                        reg_value[rb] = reg_value[ra];
                        reg_empty[rb] = 1'b0;
                    end
                end
                rvx_pkg::OP_COMP: eq_flag = (a == b);
                rvx_pkg::OP_JPEQ: begin
                    // The flag is tested first and cleared afterwards.
                    if (eq_flag) begin
                        r.jump_taken  = 1'b1;
                        r.jump_target = a;
                    end
                    eq_flag = 1'b0;
                end
                rvx_pkg::OP_DPFB: begin
                    if (!disp_en) begin
                        r.status = rvx_pkg::STS_NO_DISPLAY;
                        stopped  = 1'b1;
                    end else if (a >= rows_in_use() || b >= cols_in_use()) begin
                        r.status = rvx_pkg::STS_PIX_RANGE;
                    end else begin
                        k = int'(a) * PIX_COLS + int'(b);
                        pixels[k] = ~pixels[k];
                        r.pixel_value = pixels[k];
                    end
                end
                default: ;
            endcase
        end
        outcomes_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    // Compares one accepted result with the oldest outcome still due.
    function void check_outcome(logic [rvx_pkg::OUT_TDATA_W-1:0] word);
        rvx_pkg::result_t got;
        rvx_pkg::result_t want;
        got = rvx_pkg::result_t'(word);
        compared++;
        if (outcomes_due.size() == 0) begin
            $error("Result %h arrived with no request outstanding", word);
            errors++;
            return;
        end
        want = outcomes_due.pop_front();
        compare_field("status", 32'(want.status), 32'(got.status));
        compare_field("jump_taken", 32'(want.jump_taken), 32'(got.jump_taken));
        compare_field("jump_target", want.jump_target, got.jump_target);
        compare_field("print_valid", 32'(want.print_valid), 32'(got.print_valid));
        compare_field("print_is_char", 32'(want.print_is_char), 32'(got.print_is_char));
        compare_field("print_is_null", 32'(want.print_is_null), 32'(got.print_is_null));
        compare_field("print_value", want.print_value, got.print_value);
        compare_field("exit_code", want.exit_code, got.exit_code);
        compare_field("pixel_value", 32'(want.pixel_value), 32'(got.pixel_value));
    endfunction
endclass

module register_vm_execute_unit_test;

    localparam int  LONG_HOLD     = 200;
    localparam int  HOLD_AFTER    = 150;
    localparam int  SETTLE_CYCLES = 16;
    localparam int  PHASE_ITEMS   = 65;
    localparam real TIMEOUT_NS    = 4_000_000.0;

    typedef enum int {
        END_HALT,
        END_OCCUPIED,
        END_DEC_EMPTY,
        END_NO_DISPLAY
    } stop_kind_t;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [rvx_pkg::CFG_ADDR_W-1:0]     cfg_addr  = '0;
    logic [rvx_pkg::CFG_DIM_W-1:0]      cfg_data  = '0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [rvx_pkg::IN_TDATA_W-1:0]     s_tdata   = '0;
    logic [rvx_pkg::IN_TUSER_W-1:0]     s_tuser   = '0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [rvx_pkg::OUT_TDATA_W-1:0]    m_tdata;

    vm_shadow_machine shadow = new();
    bit               steady       = 1'b0;
    bit               sink_holding = 1'b0;
    bit               hold_done    = 1'b0;
    int               cfg_sets     = 0;

    register_vm_execute_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Operand values biased toward the wrap-around corners.
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Pixel coordinate: mostly in range, sometimes just past it or far out.
    function automatic logic [31:0] pixel_coord(input int lim);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) return $urandom_range(0, (lim > 4) ? 3 : lim - 1);
        if (roll < 8) return $urandom_range(0, lim - 1);
        if (roll < 9) return lim + $urandom_range(0, 3);
        return $urandom;
    endfunction

    // Offers one instruction request and waits until it is taken.
    task automatic send_instr(input logic [4:0] fn, input logic [31:0] a,
                              input logic [31:0] b, input logic [31:0] c,
                              input logic has_b);
        int gap;
        gap = (steady || sink_holding) ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c, b, a};
        s_tuser  <= {has_b, fn};
        do @(posedge aclk); while (!s_tready);
        shadow.accept_instr(fn, a, b, c, has_b);
    endtask

    // Stops offering and waits for every outstanding result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (shadow.outcomes_due.size() != 0);
    endtask

    // Writes all three display registers back to back.
    task automatic write_display(input logic en, input logic [rvx_pkg::CFG_DIM_W-1:0] h,
                                 input logic [rvx_pkg::CFG_DIM_W-1:0] w);
        logic [rvx_pkg::CFG_ADDR_W-1:0] idx [3];
        logic [rvx_pkg::CFG_DIM_W-1:0]  val [3];
        idx[0] = rvx_pkg::CFG_IDX_DISPLAY_ENABLED;
        idx[1] = rvx_pkg::CFG_IDX_DISPLAY_HEIGHT;
        idx[2] = rvx_pkg::CFG_IDX_DISPLAY_WIDTH;
        val[0] = {6'd0, en};
        val[1] = h;
        val[2] = w;
        for (int i = 0; i < 3; i++) begin
            cfg_addr  <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
            shadow.set_config(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        cfg_sets++;
    endtask

    function automatic logic [rvx_pkg::CFG_DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 3))
            0: return 7'd1;
            1: return 7'd64;
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    // One random instruction that never stops the machine.
    task automatic send_random_instr();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [3:0]  r0;
        logic [3:0]  r1;
        logic        hb;
        int          pick;
        a    = $urandom;
        b    = $urandom;
        c    = $urandom;
        r0   = 4'($urandom);
        r1   = 4'($urandom);
        hb   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            // A push only goes to an empty register; otherwise free one up.
            if (shadow.pick_reg(1'b1, r1))
                send_instr(rvx_pkg::OP_PUSH, rand_value(), {b[31:4], r1}, c, hb);
            else
                send_instr(rvx_pkg::OP_PURGE, {a[31:4], r0}, b, c, hb);
        end else if (pick < 16) begin
            send_instr(rvx_pkg::OP_JREQ, {a[31:4], r0},
                       b[0] ? shadow.reg_value[r0] : rand_value(), c, hb);
        end else if (pick < 24) begin
            send_instr(rvx_pkg::OP_PULL, {a[31:4], r0}, b, c, hb);
        end else if (pick < 28) begin
            send_instr(rvx_pkg::OP_PRNT, a, b, c, hb);
        end else if (pick < 34) begin
            send_instr(rvx_pkg::OP_PURGE, {a[31:4], r0}, b, c, hb);
        end else if (pick < 42) begin
            send_instr(a[0] ? rvx_pkg::OP_ADD : rvx_pkg::OP_SUB,
                       rand_value(), rand_value(), c, hb);
        end else if (pick < 50) begin
            send_instr(a[0] ? rvx_pkg::OP_ADD_R : rvx_pkg::OP_SUB_R,
                       {a[31:4], r0}, {b[31:4], r1}, c, hb);
        end else if (pick < 58) begin
            send_instr(rvx_pkg::OP_INC, {a[31:4], r0}, rand_value(), c, hb);
        end else if (pick < 64) begin
            // A decrement only targets a register that holds a value.
            if (shadow.pick_reg(1'b0, r0))
                send_instr(rvx_pkg::OP_DEC, {a[31:4], r0}, rand_value(), c, hb);
            else
                send_instr(rvx_pkg::OP_INC, {a[31:4], r0}, rand_value(), c, hb);
        end else if (pick < 70) begin
            send_instr(rvx_pkg::OP_CMRR, {a[31:4], r0}, {b[31:4], r1}, c, hb);
        end else if (pick < 78) begin
            a = rand_value();
            send_instr(rvx_pkg::OP_COMP, a, c[0] ? a : rand_value(), c, hb);
        end else if (pick < 86) begin
            send_instr(rvx_pkg::OP_JPEQ, a, b, c, hb);
        end else if (pick < 94) begin
            // Pixel toggles only in display mode; otherwise arm the flag.
            if (shadow.disp_en)
                send_instr(rvx_pkg::OP_DPFB, pixel_coord(shadow.rows_in_use()),
                           pixel_coord(shadow.cols_in_use()), c, hb);
            else
                send_instr(rvx_pkg::OP_COMP, b, b, c, hb);
        end else if (pick < 97) begin
            send_instr(rvx_pkg::OP_NOP, a, b, c, hb);
        end else begin
            send_instr(5'($urandom_range(17, 31)), a, b, c, hb);
        end
    endtask

    // Result checking on every accepted result.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            shadow.check_outcome(m_tdata);
    end

    // Result side: random back-pressure, one long hold once the run is underway.
    initial begin : result_sink
        int gap;
        forever begin
            if (!hold_done && shadow.compared >= HOLD_AFTER) begin
                hold_done    = 1'b1;
                sink_holding = 1'b1;
                gap          = LONG_HOLD;
            end else begin
                gap = steady ? 0 : pick_gap();
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            sink_holding = 1'b0;
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $error("Run did not complete in the allotted time");
        $display("FAIL register_vm_execute_unit");
        $finish;
    end

    initial begin : stimulus
        logic                           en;
        logic [rvx_pkg::CFG_DIM_W-1:0]  h;
        logic [rvx_pkg::CFG_DIM_W-1:0]  w;
        logic [3:0]                     r;
        stop_kind_t                     stop_kind;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        write_display(1'b0, rvx_pkg::CFG_DIM_RESET, rvx_pkg::CFG_DIM_RESET);

        // Text mode: every operation but halt and pixel toggle, wrap-around and empty-register cases.
        send_instr(rvx_pkg::OP_PULL, 32'h0000_0003, 32'h0, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_PUSH, 32'h7FFF_FFFF, 32'h0000_0003, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_PUSH, 32'h8000_0000, 32'hFFFF_FFF4, 32'hFFFF_FFFF, 1'b1);
        send_instr(rvx_pkg::OP_PULL, 32'hABCD_EF03, 32'h0, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_PRNT, 32'hFFFF_FF41, 32'h0, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_JREQ, 32'h0000_0003, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0);
        send_instr(rvx_pkg::OP_JREQ, 32'h0000_0004, 32'h0, 32'h0000_0055, 1'b0);
        send_instr(rvx_pkg::OP_JREQ, 32'h0000_0009, 32'h0, 32'h8000_0000, 1'b0);
        send_instr(rvx_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0005, 1'b0);
        send_instr(rvx_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001, 32'h0000_0006, 1'b0);
        send_instr(rvx_pkg::OP_ADD_R, 32'h0000_0003, 32'h0000_0009, 32'h0000_0007, 1'b0);
        send_instr(rvx_pkg::OP_SUB_R, 32'h0000_0009, 32'h0000_0004, 32'h0000_0008, 1'b0);
        // Increment of an empty register, with and without a step.
        send_instr(rvx_pkg::OP_INC, 32'h0000_000A, 32'h0, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_INC, 32'h0000_000B, 32'hFFFF_FFFF, 32'h0, 1'b1);
        send_instr(rvx_pkg::OP_DEC, 32'h0000_000A, 32'h0, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_DEC, 32'h0000_000B, 32'h8000_0000, 32'h0, 1'b1);
        // Conditional copy from an empty and from a filled register.
        send_instr(rvx_pkg::OP_CMRR, 32'h0000_000C, 32'h0000_000D, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_PULL, 32'h0000_000D, 32'h0, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_CMRR, 32'h0000_0003, 32'h0000_000D, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_PULL, 32'h0000_000D, 32'h0, 32'h0, 1'b0);
        // Jump on the flag is taken once, then the flag is clear.
        send_instr(rvx_pkg::OP_COMP, 32'h0000_0005, 32'h0000_0005, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_JPEQ, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_JPEQ, 32'h0000_0001, 32'h0, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_PURGE, 32'h0000_0003, 32'h0, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_PULL, 32'h0000_0003, 32'h0, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_instr(5'd31, 32'h0, 32'h0, 32'h0, 1'b0);

        // Display mode on a one-pixel screen: toggles, range errors, muted prints.
        drain_results();
        write_display(1'b1, 7'd1, 7'd1);
        send_instr(rvx_pkg::OP_DPFB, 32'h0, 32'h0, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_DPFB, 32'h0, 32'h0, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_DPFB, 32'h0000_0001, 32'h0, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_DPFB, 32'h0, 32'h0000_0001, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_DPFB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_PULL, 32'h0000_0004, 32'h0, 32'h0, 1'b0);
        send_instr(rvx_pkg::OP_PRNT, 32'h0000_007E, 32'h0, 32'h0, 1'b0);

        // Random phases, each under its own display setting.
        for (int p = 0; p < 6; p++) begin
            drain_results();
            case (p)
                0: begin en = 1'b1; h = 7'd64; w = 7'd64; end
                1: begin en = 1'b1; h = 7'd1;  w = 7'd64; end
                2: begin en = 1'b1; h = 7'd64; w = 7'd1;  end
                3: begin en = 1'b0; h = pick_dim(); w = pick_dim(); end
                default: begin
                    en = 1'($urandom_range(0, 1));
                    h  = pick_dim();
                    w  = pick_dim();
                end
            endcase
            write_display(en, h, w);
            steady = (p == 2);
            repeat (PHASE_ITEMS) send_random_instr();
        end
        steady = 1'b0;

        // Stop the machine one of four ways, then confirm it stays stopped.
        drain_results();
        stop_kind = stop_kind_t'($urandom_range(0, 3));
        r = 4'($urandom);
        case (stop_kind)
            END_HALT: send_instr(rvx_pkg::OP_HALT, $urandom, $urandom, $urandom, 1'b0);
            END_OCCUPIED: begin
                send_instr(rvx_pkg::OP_INC, {28'h1234567, r}, 32'h0, 32'h0, 1'b0);
                send_instr(rvx_pkg::OP_PUSH, $urandom, {28'hFEDCBA9, r}, 32'h0, 1'b0);
            end
            END_DEC_EMPTY: begin
                send_instr(rvx_pkg::OP_PURGE, {28'h0, r}, 32'h0, 32'h0, 1'b0);
                send_instr(rvx_pkg::OP_DEC, {28'h0, r}, $urandom, 32'h0, 1'b1);
            end
            default: begin
                write_display(1'b0, pick_dim(), pick_dim());
                send_instr(rvx_pkg::OP_DPFB, 32'h0, 32'h0, 32'h0, 1'b0);
            end
        endcase
        repeat (10) begin
            send_instr(5'($urandom_range(0, 31)), $urandom, $urandom, $urandom,
                       1'($urandom_range(0, 1)));
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Summary: %0d instructions over %0d display settings, %0d results checked.",
                 shadow.accepted, cfg_sets, shadow.compared);
        $display("Summary: the machine was stopped by %s and then kept answering halted.",
                 stop_kind.name());
        if (shadow.errors == 0 && shadow.outcomes_due.size() == 0) begin
            $display("PASS register_vm_execute_unit");
        end else begin
            $display("FAIL register_vm_execute_unit");
        end
        $finish;
    end

endmodule
